### hw/rtl/ecmf_pkg.sv
// Shared types and constants for the edge connectivity max-flow core.
// Used by the arc store, the vertex store and the top level.
`timescale 1ns / 1ps
`default_nettype none

package ecmf_pkg;

  // Graph limits.
  localparam int VTX_W    = 6;
  localparam int DEG_W    = 5;
  localparam int FLOW_W   = 2;
  localparam int SLOT_W   = 4;
  localparam int ARC_AW   = VTX_W + SLOT_W;
  localparam int MAX_VTX  = 64;
  localparam int MAX_DEG  = 16;
  localparam int ARC_SLOTS = 1024;

  // Search and push constants.
  localparam logic [1:0]  CAP_INF   = 2'd3;
  localparam logic [10:0] ROUND_CAP = 11'd1024;

  // Parent and bottleneck of one visited vertex.
  typedef struct packed {
    logic [VTX_W-1:0] parent;
    logic [1:0]       bn;
  } pb_t;

  // Request into the arc store.
  typedef struct packed {
    logic [ARC_AW-1:0] addr;
    logic              nbr_we;
    logic [VTX_W-1:0]  nbr_wd;
    logic              flow_we;
    logic [FLOW_W-1:0] flow_wd;
  } arc_req_t;

  // Request into the vertex store.
  typedef struct packed {
    logic [VTX_W-1:0] deg_addr;
    logic             deg_we;
    logic [DEG_W-1:0] deg_wd;
    logic             deg_clr;
    logic [VTX_W-1:0] pb_raddr;
    logic [VTX_W-1:0] pb_waddr;
    logic             pb_we;
    pb_t              pb_wd;
    logic [VTX_W-1:0] q_raddr;
    logic [VTX_W-1:0] q_waddr;
    logic             q_we;
    logic [VTX_W-1:0] q_wd;
    logic             seen_clr;
    logic             seen_set;
    logic [VTX_W-1:0] seen_idx;
    logic [VTX_W-1:0] seen_qidx;
  } vtx_req_t;

endpackage

`default_nettype wire

### hw/rtl/ecmf_arc_mem.sv
// Arc store: neighbor table and per-arc flow, one slot per adjacency entry.
// Depends on ecmf_pkg for the request type and widths.
`timescale 1ns / 1ps
`default_nettype none

module ecmf_arc_mem import ecmf_pkg::*; (
  input  logic              clk,
  input  arc_req_t          req,
  output logic [VTX_W-1:0]  nbr_rd,
  output logic [FLOW_W-1:0] flow_rd
);

  logic [VTX_W-1:0]  nbr_mem  [0:ARC_SLOTS-1];
  logic [FLOW_W-1:0] flow_mem [0:ARC_SLOTS-1];
  logic [VTX_W-1:0]  nbr_rd_r;
  logic [FLOW_W-1:0] flow_rd_r;

  // Neighbor table, read before write.
  always_ff @(posedge clk) begin
    if (req.nbr_we) begin
      nbr_mem[req.addr] <= req.nbr_wd;
    end
    nbr_rd_r <= nbr_mem[req.addr];
  end

  // Flow table, read before write.
  always_ff @(posedge clk) begin
    if (req.flow_we) begin
      flow_mem[req.addr] <= req.flow_wd;
    end
    flow_rd_r <= flow_mem[req.addr];
  end

  assign nbr_rd  = nbr_rd_r;
  assign flow_rd = flow_rd_r;

endmodule

`default_nettype wire

### hw/rtl/ecmf_vtx_mem.sv
// Vertex store: degree counts with valid bits, parent and bottleneck,
// search queue and visited bits. Depends on ecmf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ecmf_vtx_mem import ecmf_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  vtx_req_t         req,
  output logic [DEG_W-1:0] deg_rd,
  output pb_t              pb_rd,
  output logic [VTX_W-1:0] q_rd,
  output logic             seen_hit
);

  logic [DEG_W-1:0]   deg_mem [0:MAX_VTX-1];
  pb_t                pb_mem  [0:MAX_VTX-1];
  logic [VTX_W-1:0]   q_mem   [0:MAX_VTX-1];
  logic [MAX_VTX-1:0] deg_vld_r, deg_vld_nxt;
  logic [MAX_VTX-1:0] seen_r, seen_nxt;
  logic [DEG_W-1:0]   deg_rd_r;
  logic               deg_hit_r;
  pb_t                pb_rd_r;
  logic [VTX_W-1:0]   q_rd_r;

  // Degree entries that are not valid read as zero.
  always_ff @(posedge clk) begin
    if (req.deg_we) begin
      deg_mem[req.deg_addr] <= req.deg_wd;
    end
    deg_rd_r  <= deg_mem[req.deg_addr];
    deg_hit_r <= deg_vld_r[req.deg_addr];
  end

  assign deg_rd = deg_hit_r ? deg_rd_r : '0;

  // Valid bits and visited bits.
  always_comb begin
    deg_vld_nxt = deg_vld_r;
    if (req.deg_clr) begin
      deg_vld_nxt = '0;
    end else if (req.deg_we) begin
      deg_vld_nxt[req.deg_addr] = 1'b1;
    end
    seen_nxt = seen_r;
    if (req.seen_clr) begin
      seen_nxt = '0;
    end
    if (req.seen_set) begin
      seen_nxt[req.seen_idx] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deg_vld_r <= '0;
      seen_r    <= '0;
    end else begin
      deg_vld_r <= deg_vld_nxt;
      seen_r    <= seen_nxt;
    end
  end

  assign seen_hit = seen_r[req.seen_qidx];

  // Parent and bottleneck memory.
  always_ff @(posedge clk) begin
    if (req.pb_we) begin
      pb_mem[req.pb_waddr] <= req.pb_wd;
    end
    pb_rd_r <= pb_mem[req.pb_raddr];
  end

  // Search queue memory.
  always_ff @(posedge clk) begin
    if (req.q_we) begin
      q_mem[req.q_waddr] <= req.q_wd;
    end
    q_rd_r <= q_mem[req.q_raddr];
  end

  assign pb_rd = pb_rd_r;
  assign q_rd  = q_rd_r;

endmodule

`default_nettype wire

### hw/rtl/edge_connectivity_max_flow_core.sv
// Channel  | Ports                                          | Moves
// input    | in_valid in_stall in_end_a in_end_b            | one edge or end marker
//          | in_has_edge in_last_edge                       |
// result   | out_valid out_stall out_connectivity           | one connectivity result
//          | out_load_error                                 |
// config   | cfg_wr_en cfg_wr_data                          | vertex count register
//
// A request carrying an edge reads both degrees, checks them and writes the arcs; a bare
// marker only starts the computation when it is last. After the last request, each sink
// clears all 1024 arc flows, then scans arcs on the single arc-store port per search and push.
// The result register lets the next request in while a result waits.
// Reset is synchronous and clears control state, the degree valid bits and the visited bits.
// Depends on ecmf_pkg, ecmf_arc_mem and ecmf_vtx_mem.
`timescale 1ns / 1ps
`default_nettype none

module edge_connectivity_max_flow_core import ecmf_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [6:0]       cfg_wr_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [VTX_W-1:0] in_end_a,
  input  logic [VTX_W-1:0] in_end_b,
  input  logic             in_has_edge,
  input  logic             in_last_edge,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [4:0]       out_connectivity,
  output logic             out_load_error
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_LRA   = 5'd1;
  localparam logic [4:0] S_LRB   = 5'd2;
  localparam logic [4:0] S_LCHK  = 5'd3;
  localparam logic [4:0] S_LSELF = 5'd4;
  localparam logic [4:0] S_LWB   = 5'd5;
  localparam logic [4:0] S_CST   = 5'd6;
  localparam logic [4:0] S_CD0   = 5'd7;
  localparam logic [4:0] S_SWP   = 5'd8;
  localparam logic [4:0] S_BINIT = 5'd9;
  localparam logic [4:0] S_BPOP  = 5'd10;
  localparam logic [4:0] S_BPOPW = 5'd11;
  localparam logic [4:0] S_BDEG  = 5'd12;
  localparam logic [4:0] S_BRD   = 5'd13;
  localparam logic [4:0] S_BARC  = 5'd14;
  localparam logic [4:0] S_PST   = 5'd15;
  localparam logic [4:0] S_PPAR  = 5'd16;
  localparam logic [4:0] S_PDEG  = 5'd17;
  localparam logic [4:0] S_PRD   = 5'd18;
  localparam logic [4:0] S_PF    = 5'd19;
  localparam logic [4:0] S_RDEG  = 5'd20;
  localparam logic [4:0] S_RRD   = 5'd21;
  localparam logic [4:0] S_RCHK  = 5'd22;
  localparam logic [4:0] S_SINK  = 5'd23;
  localparam logic [4:0] S_FIN   = 5'd24;

  logic [4:0]        state_r, state_nxt;
  logic [6:0]        vc_r, vc_nxt;
  logic [VTX_W-1:0]  a_r, a_nxt, b_r, b_nxt;
  logic              last_r, last_nxt;
  logic [DEG_W-1:0]  da_r, da_nxt, db_r, db_nxt, dg_r, dg_nxt;
  logic              err_r, err_nxt;
  logic [4:0]        best_r, best_nxt;
  logic [6:0]        t_r, t_nxt;
  logic [ARC_AW-1:0] sw_r, sw_nxt;
  logic [6:0]        head_r, head_nxt, tail_r, tail_nxt;
  logic [VTX_W-1:0]  i_r, i_nxt, s_r, s_nxt, prev_r, prev_nxt;
  logic [1:0]        bn_r, bn_nxt, amt_r, amt_nxt;
  logic [FLOW_W-1:0] before_r, before_nxt;
  logic [DEG_W-1:0]  k_r, k_nxt;
  logic [5:0]        ftot_r, ftot_nxt;
  logic [10:0]       rounds_r, rounds_nxt;
  logic [6:0]        steps_r, steps_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [4:0]        out_conn_r, out_conn_nxt;
  logic              out_err_r, out_err_nxt;

  arc_req_t          arq;
  vtx_req_t          vrq;
  logic [VTX_W-1:0]  nbr_rd;
  logic [FLOW_W-1:0] flow_rd;
  logic [DEG_W-1:0]  deg_rd;
  pb_t               pb_rd;
  logic [VTX_W-1:0]  q_rd;
  logic              seen_hit;

  logic [6:0]        n_live;
  logic              in_acc;
  logic              self_loop, bad_idx, full;
  logic [5:0]        need;
  logic [2:0]        res3, fl_plus, fl_minus, neg_before;
  logic [1:0]        res2, mval;
  logic [6:0]        ftot_sum;
  logic [6:0]        t_next;

  ecmf_arc_mem u_arc (
    .clk     (clk),
    .req     (arq),
    .nbr_rd  (nbr_rd),
    .flow_rd (flow_rd)
  );

  ecmf_vtx_mem u_vtx (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (vrq),
    .deg_rd   (deg_rd),
    .pb_rd    (pb_rd),
    .q_rd     (q_rd),
    .seen_hit (seen_hit)
  );

  // Effective vertex count and handshake.
  assign n_live   = (vc_r > 7'(MAX_VTX)) ? 7'(MAX_VTX) : vc_r;
  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;

  // Edge checks on the two degrees just read.
  assign self_loop = (a_r == b_r);
  assign need      = self_loop ? 6'd2 : 6'd1;
  assign bad_idx   = ({1'b0, a_r} >= n_live) || ({1'b0, b_r} >= n_live);
  assign full      = ({1'b0, da_r} + need > 6'(MAX_DEG)) ||
                     ({1'b0, deg_rd} + need > 6'(MAX_DEG));

  // Residual capacity and flow updates of the arc just read.
  assign res3       = 3'd1 - {flow_rd[1], flow_rd};
  assign res2       = res3[1:0];
  assign mval       = (bn_r < res2) ? bn_r : res2;
  assign fl_plus    = {flow_rd[1], flow_rd} + {1'b0, amt_r};
  assign fl_minus   = {flow_rd[1], flow_rd} - {1'b0, amt_r};
  assign neg_before = 3'd0 - {before_r[1], before_r};
  assign ftot_sum   = {1'b0, ftot_r} + {5'd0, mval};
  assign t_next     = t_r + 7'd1;

  // Sequencer.
  always_comb begin
    state_nxt  = state_r;
    vc_nxt     = cfg_wr_en ? cfg_wr_data : vc_r;
    a_nxt      = a_r;
    b_nxt      = b_r;
    last_nxt   = last_r;
    da_nxt     = da_r;
    db_nxt     = db_r;
    dg_nxt     = dg_r;
    err_nxt    = err_r;
    best_nxt   = best_r;
    t_nxt      = t_r;
    sw_nxt     = sw_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    i_nxt      = i_r;
    s_nxt      = s_r;
    prev_nxt   = prev_r;
    bn_nxt     = bn_r;
    amt_nxt    = amt_r;
    before_nxt = before_r;
    k_nxt      = k_r;
    ftot_nxt   = ftot_r;
    rounds_nxt = rounds_r;
    steps_nxt  = steps_r;
    out_valid_nxt = (out_valid_r && out_stall);
    out_conn_nxt  = out_conn_r;
    out_err_nxt   = out_err_r;

    arq           = '0;
    arq.addr      = {i_r, k_r[SLOT_W-1:0]};
    vrq           = '0;
    vrq.seen_qidx = nbr_rd;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          a_nxt    = in_end_a;
          b_nxt    = in_end_b;
          last_nxt = in_last_edge;
          if (in_has_edge) begin
            state_nxt = S_LRA;
          end else if (in_last_edge) begin
            state_nxt = S_CST;
          end
        end
      end
      S_LRA: begin
        vrq.deg_addr = a_r;
        state_nxt    = S_LRB;
      end
      S_LRB: begin
        vrq.deg_addr = b_r;
        da_nxt       = deg_rd;
        state_nxt    = S_LCHK;
      end
      S_LCHK: begin
        db_nxt = deg_rd;
        if (bad_idx || full) begin
          err_nxt   = 1'b1;
          state_nxt = last_r ? S_CST : S_IDLE;
        end else begin
          arq.addr     = {a_r, da_r[SLOT_W-1:0]};
          arq.nbr_we   = 1'b1;
          arq.nbr_wd   = b_r;
          vrq.deg_addr = a_r;
          vrq.deg_we   = 1'b1;
          vrq.deg_wd   = da_r + need[DEG_W-1:0];
          state_nxt    = self_loop ? S_LSELF : S_LWB;
        end
      end
      S_LSELF: begin
        arq.addr   = {a_r, da_r[SLOT_W-1:0] + 4'd1};
        arq.nbr_we = 1'b1;
        arq.nbr_wd = a_r;
        state_nxt  = last_r ? S_CST : S_IDLE;
      end
      S_LWB: begin
        arq.addr     = {b_r, db_r[SLOT_W-1:0]};
        arq.nbr_we   = 1'b1;
        arq.nbr_wd   = a_r;
        vrq.deg_addr = b_r;
        vrq.deg_we   = 1'b1;
        vrq.deg_wd   = db_r + 5'd1;
        state_nxt    = last_r ? S_CST : S_IDLE;
      end
      S_CST: begin
        vrq.deg_addr = '0;
        if (n_live == 7'd0) begin
          best_nxt  = '0;
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_CD0;
        end
      end
      S_CD0: begin
        best_nxt   = deg_rd;
        t_nxt      = 7'd1;
        sw_nxt     = '0;
        ftot_nxt   = '0;
        rounds_nxt = '0;
        state_nxt  = (n_live == 7'd1) ? S_FIN : S_SWP;
      end
      // Clear every arc flow before a new sink.
      S_SWP: begin
        arq.addr    = sw_r;
        arq.flow_we = 1'b1;
        arq.flow_wd = '0;
        sw_nxt      = sw_r + ARC_AW'(1);
        if (sw_r == ARC_AW'(ARC_SLOTS - 1)) begin
          state_nxt = S_BINIT;
        end
      end
      // Start a breadth-first search from vertex 0.
      S_BINIT: begin
        vrq.seen_clr  = 1'b1;
        vrq.seen_set  = 1'b1;
        vrq.seen_idx  = '0;
        vrq.pb_waddr  = '0;
        vrq.pb_we     = 1'b1;
        vrq.pb_wd     = '{parent: '0, bn: CAP_INF};
        vrq.q_waddr   = '0;
        vrq.q_we      = 1'b1;
        vrq.q_wd      = '0;
        head_nxt      = '0;
        tail_nxt      = 7'd1;
        state_nxt     = S_BPOP;
      end
      S_BPOP: begin
        vrq.q_raddr = head_r[VTX_W-1:0];
        if (head_r < tail_r) begin
          head_nxt  = head_r + 7'd1;
          state_nxt = S_BPOPW;
        end else begin
          state_nxt = S_SINK;
        end
      end
      S_BPOPW: begin
        i_nxt        = q_rd;
        vrq.deg_addr = q_rd;
        vrq.pb_raddr = q_rd;
        state_nxt    = S_BDEG;
      end
      S_BDEG: begin
        dg_nxt    = deg_rd;
        bn_nxt    = pb_rd.bn;
        k_nxt     = '0;
        state_nxt = S_BRD;
      end
      S_BRD: begin
        arq.addr  = {i_r, k_r[SLOT_W-1:0]};
        state_nxt = (k_r < dg_r) ? S_BARC : S_BPOP;
      end
      S_BARC: begin
        k_nxt     = k_r + 5'd1;
        state_nxt = S_BRD;
        if (!seen_hit && (res2 != 2'd0)) begin
          vrq.seen_set = 1'b1;
          vrq.seen_idx = nbr_rd;
          vrq.pb_waddr = nbr_rd;
          vrq.pb_we    = 1'b1;
          vrq.pb_wd    = '{parent: i_r, bn: mval};
          if (nbr_rd == t_r[VTX_W-1:0]) begin
            // Sink reached: augment along the parent chain.
            amt_nxt    = mval;
            ftot_nxt   = ftot_sum[6] ? 6'h3F : ftot_sum[5:0];
            rounds_nxt = rounds_r + 11'd1;
            s_nxt      = t_r[VTX_W-1:0];
            steps_nxt  = '0;
            state_nxt  = S_PST;
          end else begin
            vrq.q_waddr = tail_r[VTX_W-1:0];
            vrq.q_we    = 1'b1;
            vrq.q_wd    = nbr_rd;
            tail_nxt    = tail_r + 7'd1;
          end
        end
      end
      S_PST: begin
        vrq.pb_raddr = s_r;
        if ((s_r == '0) || steps_r[6]) begin
          state_nxt = (rounds_r < ROUND_CAP) ? S_BINIT : S_SINK;
        end else begin
          state_nxt = S_PPAR;
        end
      end
      S_PPAR: begin
        prev_nxt     = pb_rd.parent;
        vrq.deg_addr = pb_rd.parent;
        state_nxt    = S_PDEG;
      end
      S_PDEG: begin
        dg_nxt    = deg_rd;
        k_nxt     = '0;
        state_nxt = S_PRD;
      end
      // Forward arc from the parent toward s.
      S_PRD: begin
        arq.addr = {prev_r, k_r[SLOT_W-1:0]};
        if (k_r < dg_r) begin
          state_nxt = S_PF;
        end else begin
          s_nxt     = prev_r;
          steps_nxt = steps_r + 7'd1;
          state_nxt = S_PST;
        end
      end
      S_PF: begin
        arq.addr     = {prev_r, k_r[SLOT_W-1:0]};
        vrq.deg_addr = s_r;
        if ((nbr_rd == s_r) && (res2 >= amt_r)) begin
          before_nxt  = flow_rd;
          arq.flow_we = 1'b1;
          arq.flow_wd = fl_plus[1:0];
          state_nxt   = S_RDEG;
        end else begin
          k_nxt     = k_r + 5'd1;
          state_nxt = S_PRD;
        end
      end
      S_RDEG: begin
        dg_nxt    = deg_rd;
        k_nxt     = '0;
        state_nxt = S_RRD;
      end
      // Paired reverse arc from s back to the parent.
      S_RRD: begin
        arq.addr = {s_r, k_r[SLOT_W-1:0]};
        if (k_r < dg_r) begin
          state_nxt = S_RCHK;
        end else begin
          s_nxt     = prev_r;
          steps_nxt = steps_r + 7'd1;
          state_nxt = S_PST;
        end
      end
      S_RCHK: begin
        arq.addr = {s_r, k_r[SLOT_W-1:0]};
        if ((nbr_rd == prev_r) && ({flow_rd[1], flow_rd} == neg_before)) begin
          arq.flow_we = 1'b1;
          arq.flow_wd = fl_minus[1:0];
          s_nxt       = prev_r;
          steps_nxt   = steps_r + 7'd1;
          state_nxt   = S_PST;
        end else begin
          k_nxt     = k_r + 5'd1;
          state_nxt = S_RRD;
        end
      end
      // Sink finished: keep the smaller cut and move on.
      S_SINK: begin
        if (ftot_r < {1'b0, best_r}) begin
          best_nxt = ftot_r[4:0];
        end
        if (t_next < n_live) begin
          t_nxt      = t_next;
          sw_nxt     = '0;
          ftot_nxt   = '0;
          rounds_nxt = '0;
          state_nxt  = S_SWP;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_conn_nxt  = best_r;
          out_err_nxt   = err_r;
          err_nxt       = 1'b0;
          vrq.deg_clr   = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vc_r        <= '0;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      vc_r        <= vc_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    last_r     <= last_nxt;
    da_r       <= da_nxt;
    db_r       <= db_nxt;
    dg_r       <= dg_nxt;
    best_r     <= best_nxt;
    t_r        <= t_nxt;
    sw_r       <= sw_nxt;
    head_r     <= head_nxt;
    tail_r     <= tail_nxt;
    i_r        <= i_nxt;
    s_r        <= s_nxt;
    prev_r     <= prev_nxt;
    bn_r       <= bn_nxt;
    amt_r      <= amt_nxt;
    before_r   <= before_nxt;
    k_r        <= k_nxt;
    ftot_r     <= ftot_nxt;
    rounds_r   <= rounds_nxt;
    steps_r    <= steps_nxt;
    out_conn_r <= out_conn_nxt;
    out_err_r  <= out_err_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_connectivity = out_conn_r;
  assign out_load_error   = out_err_r;

endmodule

`default_nettype wire

### hw/rtl/ecmf_checker.sv
// Port-level checks for the edge connectivity max-flow core, with the bind.
// Depends only on the top level's ports.
`timescale 1ns / 1ps
`default_nettype none

module ecmf_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       in_last_edge,
  input logic       out_valid,
  input logic       out_stall,
  input logic [4:0] out_connectivity
);

  // No result is pending right after reset.
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A last request always starts a computation that holds off the input.
  a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_last_edge) |=> in_stall)
    else $error("input not held after last request");

  // A new result appears only while the core is busy.
  a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared while idle");

  // Connectivity never exceeds the degree bound.
  a_conn_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_connectivity <= 5'd16))
    else $error("connectivity out of range");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_connectivity)))
    else $error("stalled result changed");

endmodule

bind edge_connectivity_max_flow_core ecmf_checker u_ecmf_checker (.*);

`default_nettype wire
